### rtl/vsfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfm_pkg
// types and constants shared by the vertical segment filter and merge block
// ----------------------------------------------------------------------------
package vsfm_pkg;

	localparam int CW = 12;   // coordinate width
	localparam int WW = CW + 1;
	localparam int CFG_DW = 12;
	localparam int CFG_AW = 1;

	localparam logic [CFG_AW-1:0] REG_MIN_LENGTH     = 1'b0;
	localparam logic [CFG_AW-1:0] REG_MERGE_DISTANCE = 1'b1;

	localparam logic [8:0] SLOPE_DX = 9'd256;
	localparam logic [5:0] SLOPE_DY = 6'd45;
	localparam logic [WW-1:0] MIN_WIDTH = WW'(3);

	typedef struct packed {
		logic [CW-1:0] start_x;
		logic [CW-1:0] start_y;
		logic [CW-1:0] end_x;
		logic [CW-1:0] end_y;
		logic          final_segment;
	} seg_in_t;

	typedef struct packed {
		logic [WW-1:0] center_position;
		logic [CW-1:0] left_x;
		logic [CW-1:0] top_y;
		logic [WW-1:0] box_width;
		logic [WW-1:0] box_height;
		logic          last_entry;
		logic          list_empty;
		logic          store_overflow;
	} box_out_t;

	// classified segment handed from front to back
	typedef struct packed {
		logic          keep;
		logic          fin;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [WW-1:0] w;
		logic [WW-1:0] h;
		logic [WW-1:0] pos;
	} cls_t;

	typedef enum logic [1:0] {
		FR_IDLE, FR_SQRT, FR_DONE
	} front_st_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_INS, BK_MRG, BK_MSCAN, BK_EMIT
	} back_st_t;

endpackage

### rtl/vsfm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfm_front
// angle test, bit-serial integer square root, and box construction
// ----------------------------------------------------------------------------
module vsfm_front
	import vsfm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  seg_in_t       in_data,
	input  logic [CW-1:0] min_length,
	output logic          cls_valid,
	input  logic          cls_ready,
	output cls_t          cls_data
);

	localparam int RW = 2 * CW + 1;   // radicand width
	localparam int NSTEP = (RW + 1) / 2;
	localparam int SCW = $clog2(NSTEP + 1);

	front_st_t     st_q, st_d;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [RW+1:0] bit_q;
	logic [SCW-1:0] cnt_q;
	logic [CW-1:0] adx_q, x_q, y_q;
	logic          fin_q, steep_q;
	logic [CW-1:0] adx, ady, mnx, mny;
	logic [RW+1:0] trial;
	logic [WW-1:0] wid;

	assign adx = (in_data.start_x > in_data.end_x) ? in_data.start_x - in_data.end_x
	                                                : in_data.end_x - in_data.start_x;
	assign ady = (in_data.start_y > in_data.end_y) ? in_data.start_y - in_data.end_y
	                                                : in_data.end_y - in_data.start_y;
	assign mnx = (in_data.start_x < in_data.end_x) ? in_data.start_x : in_data.end_x;
	assign mny = (in_data.start_y < in_data.end_y) ? in_data.start_y : in_data.end_y;
	assign trial = {2'b00, root_q} + bit_q;
	assign wid = ({1'b0, adx_q} + WW'(1) < MIN_WIDTH) ? MIN_WIDTH : {1'b0, adx_q} + WW'(1);

	assign in_ready = (st_q == FR_IDLE);
	assign cls_valid = (st_q == FR_DONE);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			FR_IDLE: if (in_valid) st_d = FR_SQRT;
			FR_SQRT: if (cnt_q == SCW'(NSTEP - 1)) st_d = FR_DONE;
			FR_DONE: if (cls_ready) st_d = FR_IDLE;
			default: st_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= FR_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (st_q == FR_IDLE && in_valid) begin
			rem_q   <= RW'(adx) * RW'(adx) + RW'(ady) * RW'(ady);
			root_q  <= '0;
			bit_q   <= (RW + 2)'(1) << (2 * (NSTEP - 1));
			cnt_q   <= '0;
			adx_q   <= adx;
			x_q     <= mnx;
			y_q     <= mny;
			fin_q   <= in_data.final_segment;
			steep_q <= ((CW + 9)'(adx) * SLOPE_DX) < ((CW + 9)'(ady) * SLOPE_DY);
		end else if (st_q == FR_SQRT) begin
			cnt_q <= cnt_q + SCW'(1);
			bit_q <= bit_q >> 2;
			if ({2'b00, rem_q} >= trial) begin
				rem_q  <= RW'({2'b00, rem_q} - trial);
				root_q <= RW'((root_q >> 1) + bit_q);
			end else begin
				root_q <= root_q >> 1;
			end
		end
	end

	always_comb begin
		cls_data.fin  = fin_q;
		cls_data.keep = steep_q && (root_q >= RW'(min_length));
		cls_data.x    = x_q;
		cls_data.y    = y_q;
		cls_data.w    = wid;
		cls_data.h    = WW'(root_q);
		cls_data.pos  = WW'({1'b0, x_q} + (wid >> 1));
	end

endmodule

### rtl/vsfm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfm_fifo
// short queue between classification and the store
// ----------------------------------------------------------------------------
module vsfm_fifo
	import vsfm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cls_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cls_t rd_data
);

	cls_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");

endmodule

### rtl/vsfm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfm_back
// sorted insertion, merge walk and list emission
// ----------------------------------------------------------------------------
module vsfm_back
	import vsfm_pkg::*;
#(
	parameter int MAX_LINES = 32
)(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cls_valid,
	output logic          cls_ready,
	input  cls_t          cls_data,
	input  logic [7:0]    merge_distance,
	output logic          out_valid,
	input  logic          out_ready,
	output box_out_t      out_data
);

	localparam int IW = $clog2(MAX_LINES);
	localparam int NW = $clog2(MAX_LINES + 1);

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [WW-1:0] w;
		logic [WW-1:0] h;
		logic [WW-1:0] pos;
	} box_t;

	back_st_t st_q, st_d;
	box_t     srt_q [MAX_LINES];
	box_t     mrg_q [MAX_LINES];
	logic [NW-1:0] scnt_q, mcnt_q, at_q, i_q, j_q, k_q;
	logic     drop_q, fin_q;
	box_t     nb_q, cur_q, mj_q, srd_q;
	logic     shift_ok, hit, full;
	logic [WW-1:0] dif;
	logic     oval_q;
	box_out_t od_q;

	assign full = (scnt_q == NW'(MAX_LINES));
	assign cls_ready = (st_q == BK_IDLE);
	assign shift_ok = (at_q != '0) && (srd_q.pos > nb_q.pos);
	assign dif = (cur_q.pos > mj_q.pos) ? cur_q.pos - mj_q.pos : mj_q.pos - cur_q.pos;
	// only entries below the merged count can match
	assign hit = (j_q != mcnt_q) && (dif < WW'(merge_distance));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (cls_valid) begin
				if (cls_data.keep && !full) st_d = BK_INS;
				else if (cls_data.fin) st_d = BK_MRG;
			end
			BK_INS: if (!shift_ok) st_d = fin_q ? BK_MRG : BK_IDLE;
			BK_MRG: if (i_q == scnt_q) st_d = BK_EMIT; else st_d = BK_MSCAN;
			BK_MSCAN: if (j_q == mcnt_q || hit) st_d = BK_MRG;
			BK_EMIT: if (!oval_q || out_ready) begin
				if (k_q + NW'(1) >= mcnt_q) st_d = BK_IDLE;
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE; scnt_q <= '0; mcnt_q <= '0; drop_q <= 1'b0; oval_q <= 1'b0;
			at_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0; fin_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_EMIT && (!oval_q || out_ready)) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
			unique case (st_q)
				BK_IDLE: if (cls_valid) begin
					fin_q <= cls_data.fin;
					at_q  <= scnt_q;
					i_q   <= '0;
					mcnt_q <= '0;
					if (cls_data.keep && full) drop_q <= 1'b1;
				end
				BK_INS: if (shift_ok) at_q <= at_q - NW'(1);
					else begin
						scnt_q <= scnt_q + NW'(1);
						i_q <= '0; mcnt_q <= '0;
					end
				BK_MRG: begin j_q <= '0; k_q <= '0; end
				BK_MSCAN: begin
					if (hit) i_q <= i_q + NW'(1);
					else if (j_q == mcnt_q) begin
						mcnt_q <= mcnt_q + NW'(1);
						i_q <= i_q + NW'(1);
					end else j_q <= j_q + NW'(1);
				end
				BK_EMIT: if (!oval_q || out_ready) begin
					k_q <= k_q + NW'(1);
					if (k_q + NW'(1) >= mcnt_q) begin
						scnt_q <= '0; mcnt_q <= '0; drop_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// store memories, read registered at the next index
	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && cls_valid) begin
			nb_q  <= '{x: cls_data.x, y: cls_data.y, w: cls_data.w, h: cls_data.h,
			           pos: cls_data.pos};
			srd_q <= srt_q[IW'(scnt_q - NW'(1))];
		end
		if (st_q == BK_INS) begin
			if (shift_ok) begin
				srt_q[IW'(at_q)] <= srd_q;
				srd_q <= srt_q[IW'(at_q - NW'(2))];
			end else srt_q[IW'(at_q)] <= nb_q;
		end
		if (st_q == BK_MRG) begin
			cur_q <= srt_q[IW'(i_q)];
			mj_q  <= mrg_q[0];
		end
		if (st_q == BK_MSCAN) begin
			if (hit) begin
				if (cur_q.h > mj_q.h) mrg_q[IW'(j_q)] <= cur_q;
			end else if (j_q == mcnt_q) mrg_q[IW'(j_q)] <= cur_q;
			else mj_q <= mrg_q[IW'(j_q + NW'(1))];
		end
		if (st_q == BK_EMIT && (!oval_q || out_ready)) begin
			od_q.center_position <= (mcnt_q == '0) ? '0 : mrg_q[IW'(k_q)].pos;
			od_q.left_x          <= (mcnt_q == '0) ? '0 : mrg_q[IW'(k_q)].x;
			od_q.top_y           <= (mcnt_q == '0) ? '0 : mrg_q[IW'(k_q)].y;
			od_q.box_width       <= (mcnt_q == '0) ? '0 : mrg_q[IW'(k_q)].w;
			od_q.box_height      <= (mcnt_q == '0) ? '0 : mrg_q[IW'(k_q)].h;
			od_q.last_entry      <= (k_q + NW'(1) >= mcnt_q);
			od_q.list_empty      <= (mcnt_q == '0);
			od_q.store_overflow  <= drop_q;
		end
	end

	assign out_valid = oval_q;
	assign out_data  = od_q;

	assert property (@(posedge clk) disable iff (!arst_n) scnt_q <= NW'(MAX_LINES))
		else $error("sorted count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) mcnt_q <= scnt_q)
		else $error("merged count exceeds sorted count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("result changed while stalled");

endmodule

### rtl/vertical_segment_filter_and_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_segment_filter_and_merge
// keeps near-vertical long segments, sorts their boxes and merges neighbors
// ----------------------------------------------------------------------------
// front: the square root runs 13 root steps, one per cycle, before the result goes to
// the queue; the back then shifts larger entries up one by one for the sorted insert
// final segment: merge walk over the sorted entries, then one result beat per cycle
// while out_ready allows; the front and the back each take a new segment only after
// they are through with the last one
// reset: counts, flags and handshakes clear; registers return to 30 and 10
module vertical_segment_filter_and_merge
	import vsfm_pkg::*;
#(
	parameter int MAX_LINES = 32
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  seg_in_t           in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output box_out_t          out_data,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	logic [CW-1:0] min_length_q;
	logic [7:0]    merge_distance_q;
	logic          fv, fr, bv, br;
	cls_t          fd, bd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q     <= CW'(30);
			merge_distance_q <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_LENGTH:     min_length_q     <= cfg_wdata;
				REG_MERGE_DISTANCE: merge_distance_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// front: classify one segment
	vsfm_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.min_length(min_length_q),
		.cls_valid(fv), .cls_ready(fr), .cls_data(fd)
	);

	// two-entry queue decouples front from store work
	vsfm_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(fv), .wr_ready(fr), .wr_data(fd),
		.rd_valid(bv), .rd_ready(br), .rd_data(bd)
	);

	// back: insert, merge, emit
	vsfm_back #(.MAX_LINES(MAX_LINES)) u_back (
		.clk, .arst_n,
		.cls_valid(bv), .cls_ready(br), .cls_data(bd),
		.merge_distance(merge_distance_q),
		.out_valid, .out_ready, .out_data
	);

endmodule
